@@ src/szsf_pkg.sv @@
// Shared types and constants for the safezone stop filter.
// Used by safezone_stop_filter_core; depends on nothing.
`default_nettype none

package szsf_pkg;

   localparam int PRICE_W    = 32;
   localparam int FALL_DEPTH = 64;
   localparam int FALL_AW    = 6;
   localparam int HOLD_DEPTH = 16;
   localparam int HOLD_AW    = 4;
   localparam int FCNT_W     = 6;               // at most FALL_DEPTH - 1 falls
   localparam int FSUM_W     = PRICE_W + FCNT_W;
   localparam int GAIN_W     = 16;
   localparam int FWIN_W     = 7;
   localparam int HWIN_W     = 5;
   localparam int SEEN_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // gain * fall_sum, split in two halves of the sum
   localparam int SPLIT_W    = FSUM_W / 2;
   localparam int PROD_W     = GAIN_W + FSUM_W;
   localparam int HALF_W     = GAIN_W + FSUM_W - SPLIT_W;
   localparam int GAIN_FRAC  = 8;
   localparam int QUO_W      = PROD_W - GAIN_FRAC;
   localparam int DIV_STEPS  = QUO_W / 2;      // two quotient bits per cycle
   localparam int DCNT_W     = 5;

   localparam logic [FWIN_W-1:0] FALL_WINDOW_RST = 7'd10;
   localparam logic [HWIN_W-1:0] HOLD_WINDOW_RST = 5'd3;
   localparam logic [GAIN_W-1:0] GAIN_RST        = 16'd512;
   localparam logic [FWIN_W-1:0] FALL_WINDOW_MIN = 7'd2;
   localparam logic [FWIN_W-1:0] FALL_WINDOW_MAX = 7'(FALL_DEPTH);
   localparam logic [HWIN_W-1:0] HOLD_WINDOW_MIN = 5'd1;
   localparam logic [HWIN_W-1:0] HOLD_WINDOW_MAX = 5'(HOLD_DEPTH);
   localparam logic [SEEN_W-1:0] SEEN_MAX        = 7'd127;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALL_WINDOW = 2'd0,
      CSR_HOLD_WINDOW = 2'd1,
      CSR_GAIN        = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FUPD,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_CAND,
      ST_WRITEC,
      ST_WALK,
      ST_WLAST,
      ST_RESULT
   } seq_state_type;

endpackage

`default_nettype wire

@@ src/safezone_stop_filter_core.sv @@
// Safezone stop filter (long side): fall ring, average fall divider and
// candidate maximum over a small ring memory. Depends on szsf_pkg.
`default_nettype none

// Usage
//  - req_*: one price word per handshake (unsigned, 16 fraction bits).
//  - rsp_*: one result word per price: stop level in tdata, level-valid in
//    tuser. level_valid rises once fall_window + hold_window - 2 prices
//    preceded the current one.
//  - csr_*: register writes (0 fall_window, 1 hold_window, 2 gain). Write only
//    while no price is in flight. A window write restarts the series; a gain
//    write keeps the history.
// Flow
//  - One price is worked on at a time. When the fall window holds no fall,
//    the average fall is skipped; otherwise the fall sum is multiplied by
//    the gain in halves (ST_MUL), the halves are added (ST_ADD) and a
//    radix-4 divider takes the average fall. A one-entry-per-cycle walk of
//    the candidate memory follows, and the next price is taken once the
//    result has been loaded into the output register.
//  - The result sits in an output register, so a stalled receiver does not
//    hold off the next price; only the following result waits for it.
// Reset
//  - Registers return to 10 / 3 / 2.0 and the history is empty: valid bits
//    mark both ring memories unwritten, so no clearing pass is needed.
module safezone_stop_filter_core
   import szsf_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [PRICE_W-1:0]     req_tdata,   // [31:0] price
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [PRICE_W-1:0]     rsp_tdata,   // [31:0] stop_level
   output logic                   rsp_tuser,   // [0] level_valid
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   // ---------------- state and registers ----------------
   seq_state_type             state_ff, state_in;

   logic [FWIN_W-1:0]         fall_window_ff, fall_window_in;
   logic [HWIN_W-1:0]         hold_window_ff, hold_window_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;

   logic [PRICE_W-1:0]        prev_price_ff, prev_price_in;
   logic [FSUM_W-1:0]         fall_sum_ff, fall_sum_in;
   logic [FCNT_W-1:0]         fall_count_ff, fall_count_in;
   logic [FALL_AW-1:0]        fall_ptr_ff, fall_ptr_in;
   logic [FALL_DEPTH-1:0]     fall_vld_ff, fall_vld_in;
   logic [HOLD_AW-1:0]        cand_ptr_ff, cand_ptr_in;
   logic [HOLD_DEPTH-1:0]     cand_vld_ff, cand_vld_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;

   logic [PRICE_W-1:0]        price_ff, price_in;
   logic                      have_prev_ff, have_prev_in;
   logic                      lvl_valid_ff, lvl_valid_in;
   logic [HALF_W-1:0]         prod_lo_ff, prod_lo_in;
   logic [HALF_W-1:0]         prod_hi_ff, prod_hi_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [FCNT_W-1:0]         rem_ff, rem_in;
   logic [DCNT_W-1:0]         div_cnt_ff, div_cnt_in;
   logic [PRICE_W-1:0]        cand_ff, cand_in;
   logic [HOLD_AW-1:0]        walk_idx_ff, walk_idx_in;
   logic [PRICE_W-1:0]        best_ff, best_in;
   logic                      cmp_ff;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [PRICE_W-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tuser_ff, rsp_tuser_in;

   // memories and their registered read data
   logic [PRICE_W-1:0]        fall_mem [FALL_DEPTH];
   logic [PRICE_W-1:0]        fall_q_ff;
   logic [PRICE_W-1:0]        cand_mem [HOLD_DEPTH];
   logic [PRICE_W-1:0]        cand_q_ff;
   logic                      cand_rv_ff;

   // ---------------- derived values ----------------
   logic [FWIN_W-1:0]         n1;
   logic [HWIN_W-1:0]         n2;
   logic [FWIN_W-1:0]         diffs;
   logic [SEEN_W-1:0]         valid_after;
   logic                      accept;
   logic                      csr_we;
   logic                      csr_restart;
   logic                      out_free;
   logic                      out_load;
   logic                      fall_we;
   logic                      cand_we;
   logic                      last_step;
   logic                      walk_done;

   logic [PRICE_W-1:0]        old_fall;
   logic [PRICE_W-1:0]        new_fall;
   logic [FCNT_W-1:0]         count_upd;
   logic [PROD_W-1:0]         product;
   logic [FCNT_W:0]           r1, r2;
   logic [FCNT_W-1:0]         r1_kept, r2_kept;
   logic                      b1, b2;

   always_comb begin
      n1 = fall_window_ff;
      if (fall_window_ff < FALL_WINDOW_MIN) begin
         n1 = FALL_WINDOW_MIN;
      end else if (fall_window_ff > FALL_WINDOW_MAX) begin
         n1 = FALL_WINDOW_MAX;
      end
      n2 = hold_window_ff;
      if (hold_window_ff < HOLD_WINDOW_MIN) begin
         n2 = HOLD_WINDOW_MIN;
      end else if (hold_window_ff > HOLD_WINDOW_MAX) begin
         n2 = HOLD_WINDOW_MAX;
      end
   end

   assign diffs       = n1 - FWIN_W'(1);
   assign valid_after = SEEN_W'(n1) + SEEN_W'(n2) - SEEN_W'(2);

   assign accept      = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign csr_we      = csr_valid && csr_ready;
   assign csr_restart = csr_we && (csr_index == CSR_FALL_WINDOW
                                   || csr_index == CSR_HOLD_WINDOW);
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign last_step   = (div_cnt_ff == DCNT_W'(DIV_STEPS - 1));
   assign walk_done   = (walk_idx_ff == HOLD_AW'(n2 - HWIN_W'(1)));

   // fall ring update terms
   assign old_fall  = fall_vld_ff[fall_ptr_ff] ? fall_q_ff : '0;
   assign new_fall  = (prev_price_ff > price_ff) ? prev_price_ff - price_ff : '0;
   assign count_upd = fall_count_ff - FCNT_W'(old_fall != '0)
                      + FCNT_W'(new_fall != '0);

   assign product = (PROD_W'(prod_hi_ff) << SPLIT_W) + PROD_W'(prod_lo_ff);

   // two restoring divide steps per cycle, divisor is the fall count
   always_comb begin
      r1      = {rem_ff, quo_ff[QUO_W-1]};
      b1      = (r1 >= {1'b0, fall_count_ff});
      r1_kept = b1 ? FCNT_W'(r1 - {1'b0, fall_count_ff}) : r1[FCNT_W-1:0];
      r2      = {r1_kept, quo_ff[QUO_W-2]};
      b2      = (r2 >= {1'b0, fall_count_ff});
      r2_kept = b2 ? FCNT_W'(r2 - {1'b0, fall_count_ff}) : r2[FCNT_W-1:0];
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_FUPD;
         ST_FUPD:   state_in = (fall_count_in == '0) ? ST_WRITEC : ST_MUL;
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = ST_DIV;
         ST_DIV:    if (last_step) state_in = ST_CAND;
         ST_CAND:   state_in = ST_WRITEC;
         ST_WRITEC: state_in = ST_WALK;
         ST_WALK:   if (walk_done) state_in = ST_WLAST;
         ST_WLAST:  state_in = ST_RESULT;
         ST_RESULT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      fall_we    = 1'b0;
      cand_we    = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_FUPD:   fall_we    = have_prev_ff;
         ST_WRITEC: cand_we    = 1'b1;
         ST_RESULT: out_load   = out_free;
         default:   req_tready = 1'b0;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      fall_window_in = fall_window_ff;
      hold_window_in = hold_window_ff;
      gain_in        = gain_ff;
      prev_price_in  = prev_price_ff;
      fall_sum_in    = fall_sum_ff;
      fall_count_in  = fall_count_ff;
      fall_ptr_in    = fall_ptr_ff;
      fall_vld_in    = fall_vld_ff;
      cand_ptr_in    = cand_ptr_ff;
      cand_vld_in    = cand_vld_ff;
      seen_in        = seen_ff;
      price_in       = price_ff;
      have_prev_in   = have_prev_ff;
      lvl_valid_in   = lvl_valid_ff;
      prod_lo_in     = prod_lo_ff;
      prod_hi_in     = prod_hi_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      cand_in        = cand_ff;
      walk_idx_in    = walk_idx_ff;
      best_in        = best_ff;

      // take a price, note validity before counting it
      if (accept) begin
         price_in     = req_tdata;
         have_prev_in = (seen_ff != '0);
         lvl_valid_in = (seen_ff >= valid_after);
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end

      // retire the oldest difference, push the new one
      if (state_ff == ST_FUPD) begin
         prev_price_in = price_ff;
         cand_in       = price_ff;
         if (have_prev_ff) begin
            fall_sum_in  = fall_sum_ff - FSUM_W'(old_fall) + FSUM_W'(new_fall);
            fall_count_in = count_upd;
            fall_vld_in[fall_ptr_ff] = 1'b1;
            fall_ptr_in = (FWIN_W'(fall_ptr_ff) + FWIN_W'(1) >= diffs)
                          ? '0 : fall_ptr_ff + FALL_AW'(1);
         end
      end

      if (state_ff == ST_MUL) begin
         prod_lo_in = HALF_W'(gain_ff * fall_sum_ff[SPLIT_W-1:0]);
         prod_hi_in = HALF_W'(gain_ff * fall_sum_ff[FSUM_W-1:SPLIT_W]);
      end

      // drop the Q8.8 fraction before dividing by the count
      if (state_ff == ST_ADD) begin
         quo_in     = product[PROD_W-1:GAIN_FRAC];
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (state_ff == ST_DIV) begin
         quo_in     = {quo_ff[QUO_W-3:0], b1, b2};
         rem_in     = r2_kept;
         div_cnt_in = div_cnt_ff + DCNT_W'(1);
      end

      if (state_ff == ST_CAND) begin
         cand_in = (quo_ff >= QUO_W'(price_ff)) ? '0
                   : price_ff - PRICE_W'(quo_ff);
      end

      if (state_ff == ST_WRITEC) begin
         cand_vld_in[cand_ptr_ff] = 1'b1;
         cand_ptr_in = (HWIN_W'(cand_ptr_ff) + HWIN_W'(1) >= n2)
                       ? '0 : cand_ptr_ff + HOLD_AW'(1);
         walk_idx_in = '0;
         best_in     = '0;
      end

      if (state_ff == ST_WALK) begin
         walk_idx_in = walk_idx_ff + HOLD_AW'(1);
      end

      // compare the entry read in the previous cycle
      if (cmp_ff && cand_rv_ff && cand_q_ff > best_ff) begin
         best_in = cand_q_ff;
      end

      // register writes; window writes restart the series
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FALL_WINDOW: fall_window_in = csr_data[FWIN_W-1:0];
            CSR_HOLD_WINDOW: hold_window_in = csr_data[HWIN_W-1:0];
            CSR_GAIN:        gain_in        = csr_data[GAIN_W-1:0];
            default:         gain_in        = gain_ff;
         endcase
      end
      if (csr_restart) begin
         prev_price_in = '0;
         fall_sum_in   = '0;
         fall_count_in = '0;
         fall_ptr_in   = '0;
         fall_vld_in   = '0;
         cand_ptr_in   = '0;
         cand_vld_in   = '0;
         seen_in       = '0;
      end
   end

   // output register: load a finished result, drop it once taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = best_ff;
         rsp_tuser_in  = lvl_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fall_window_ff <= FALL_WINDOW_RST;
         hold_window_ff <= HOLD_WINDOW_RST;
         gain_ff        <= GAIN_RST;
         prev_price_ff  <= '0;
         fall_sum_ff    <= '0;
         fall_count_ff  <= '0;
         fall_ptr_ff    <= '0;
         fall_vld_ff    <= '0;
         cand_ptr_ff    <= '0;
         cand_vld_ff    <= '0;
         seen_ff        <= '0;
         rsp_tvalid_ff  <= 1'b0;
         cmp_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fall_window_ff <= fall_window_in;
         hold_window_ff <= hold_window_in;
         gain_ff        <= gain_in;
         prev_price_ff  <= prev_price_in;
         fall_sum_ff    <= fall_sum_in;
         fall_count_ff  <= fall_count_in;
         fall_ptr_ff    <= fall_ptr_in;
         fall_vld_ff    <= fall_vld_in;
         cand_ptr_ff    <= cand_ptr_in;
         cand_vld_ff    <= cand_vld_in;
         seen_ff        <= seen_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         cmp_ff         <= (state_ff == ST_WALK);
      end
   end

   always_ff @(posedge clock) begin
      price_ff     <= price_in;
      have_prev_ff <= have_prev_in;
      lvl_valid_ff <= lvl_valid_in;
      prod_lo_ff   <= prod_lo_in;
      prod_hi_ff   <= prod_hi_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      cand_ff      <= cand_in;
      walk_idx_ff  <= walk_idx_in;
      best_ff      <= best_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // fall ring: read the entry under the pointer every cycle
   always_ff @(posedge clock) begin
      if (fall_we) begin
         fall_mem[fall_ptr_ff] <= new_fall;
      end
      fall_q_ff <= fall_mem[fall_ptr_ff];
   end

   // candidate ring: write at the pointer, read at the walk index
   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_mem[cand_ptr_ff] <= cand_ff;
      end
      cand_q_ff  <= cand_mem[walk_idx_ff];
      cand_rv_ff <= cand_vld_ff[walk_idx_ff];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------- assertions ----------------
   a_empty_window_no_sum: assert property (@(posedge clock) disable iff (reset)
      fall_count_ff == '0 |-> fall_sum_ff == '0)
      else $error("fall sum nonzero with no falls in the window");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < fall_count_ff)
      else $error("divider remainder not below the fall count");

   a_fall_ptr_range: assert property (@(posedge clock) disable iff (reset)
      FWIN_W'(fall_ptr_ff) < diffs)
      else $error("fall pointer beyond the difference window");

   a_cand_ptr_range: assert property (@(posedge clock) disable iff (reset)
      HWIN_W'(cand_ptr_ff) < n2)
      else $error("candidate pointer beyond the hold window");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && out_free |=> rsp_tvalid_ff && state_ff == ST_IDLE)
      else $error("finished result not presented");

endmodule

`default_nettype wire
